@@ sv/fba_pkg.sv @@
// Package with constants, types and result codes of the file block allocator.
`default_nettype none
package fba_pkg;
  localparam int MaxBlocks = 64;
  localparam int MaxFiles  = 64;
  localparam int BlkW      = $clog2(MaxBlocks);
  localparam int IdW       = 6;
  localparam int CntW      = BlkW + 1;
  localparam int QDepth    = 2;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoSpace = 2'd1;
  localparam logic [1:0] StUnknown = 2'd2;
  localparam logic [1:0] StInUse   = 2'd3;

  localparam logic       CmdAlloc   = 1'b0;
  localparam logic       CmdRelease = 1'b1;

  localparam logic       CfgBlockSize   = 1'b0;
  localparam logic       CfgBlocksInUse = 1'b1;

  localparam logic [7:0] BlockSizeReset = 8'd127;
  localparam logic [6:0] InUseReset     = 7'd60;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  file_id;
    logic [15:0] size_bytes;
  } req_t;

  typedef struct packed {
    logic        has_block;
    logic [5:0]  block_number;
    logic [7:0]  fragment;
    logic [1:0]  status;
    logic        last;
  } res_t;
endpackage
`default_nettype wire

@@ sv/fba_if.sv @@
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface fba_req_if import fba_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fba_res_if import fba_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/fba_front.sv @@
// Request queue: holds accepted requests until the back end takes them.
`default_nettype none
module fba_front import fba_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  fba_req_if.sink in,
  output logic  q_valid_o,
  output req_t  q_data_o,
  input  wire   q_pop_i
);
  req_t        mem_q [QDepth];
  logic [0:0]  wr_q, rd_q;
  logic [1:0]  cnt_q;

  assign in.ready  = (cnt_q != 2'(QDepth));
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (in.valid && in.ready) begin
        mem_q[wr_q] <= in.data;
        wr_q <= wr_q + 1'b1;
      end
      if (q_pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + 2'(in.valid && in.ready) - 2'(q_pop_i);
    end
  end
endmodule
`default_nettype wire

@@ sv/fba_back.sv @@
// Back end: divide, count free blocks, alloc (res free) or free one block per cycle.
`default_nettype none
module fba_back import fba_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        q_valid_i,
  input  req_t       q_data_i,
  output logic       q_pop_o,
  input  wire        cfg_we_i,
  input  wire [0:0]  cfg_idx_i,
  input  wire [7:0]  cfg_data_i,
  fba_res_if.source  out
);
  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_COUNT, S_ALLOC, S_REL, S_OUT
  } state_e;

  state_e           state_q;
  logic [7:0]       bs_q;
  logic [6:0]       inuse_q;
  logic [MaxBlocks-1:0] free_q;
  logic [MaxFiles-1:0]  present_q;
  logic [IdW-1:0]   owner_q [MaxBlocks];
  logic [IdW-1:0]   own_rd_q;
  req_t             req_q;
  logic [16:0]      rem_q;      // running remainder of the size
  logic [16:0]      need_q;     // block count, grows by one per subtraction
  logic [CntW-1:0]  avail_q;
  logic [CntW-1:0]  idx_q;
  logic [CntW-1:0]  lim_q;
  logic [16:0]      taken_q;
  logic [7:0]       frag_q;
  logic [1:0]       st_q;
  logic             ovalid_q;
  res_t             odata_q;

  logic [7:0] bs_eff;
  logic       out_free;
  logic       oset;
  logic [BlkW-1:0] bi;
  logic [BlkW-1:0] bi_prev;

  assign bs_eff    = (bs_q == 8'd0) ? 8'd1 : bs_q;
  assign out_free  = !ovalid_q || out.ready;
  assign out.valid = ovalid_q;
  assign out.data  = odata_q;
  assign q_pop_o   = (state_q == S_IDLE) && q_valid_i;
  assign bi        = idx_q[BlkW-1:0];
  assign bi_prev   = bi - 1'b1;
  assign oset      = out_free && (((state_q == S_ALLOC) && free_q[bi]) ||
                                  (state_q == S_OUT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      bs_q      <= BlockSizeReset;
      inuse_q   <= InUseReset;
      free_q    <= '1;
      present_q <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgBlockSize) bs_q <= cfg_data_i;
        else inuse_q <= cfg_data_i[6:0];
      end
      ovalid_q <= oset || (ovalid_q && !out.ready);
      case (state_q)
        S_IDLE: if (q_valid_i) begin
          req_q   <= q_data_i;
          rem_q   <= {1'b0, q_data_i.size_bytes};
          need_q  <= '0;
          avail_q <= '0;
          idx_q   <= '0;
          taken_q <= '0;
          lim_q   <= (inuse_q > 7'(MaxBlocks)) ? CntW'(MaxBlocks) : CntW'(inuse_q);
          if (q_data_i.cmd == CmdRelease) begin
            if (!present_q[q_data_i.file_id]) begin
              st_q     <= StUnknown;
              state_q  <= S_OUT;
            end else begin
              present_q[q_data_i.file_id] <= 1'b0;
              state_q <= S_REL;
            end
          end else if (present_q[q_data_i.file_id]) begin
            st_q    <= StInUse;
            state_q <= S_OUT;
          end else begin
            state_q <= S_DIV;
          end
        end
        // Ceiling division by repeated subtraction; also yields the fragment.
        S_DIV: begin
          if (rem_q == 17'd0) begin
            frag_q  <= 8'd0;
            state_q <= S_COUNT;
          end else if (rem_q <= {9'd0, bs_eff}) begin
            frag_q  <= bs_eff - rem_q[7:0];
            need_q  <= need_q + 17'd1;
            state_q <= S_COUNT;
          end else begin
            rem_q  <= rem_q - {9'd0, bs_eff};
            need_q <= need_q + 17'd1;
          end
        end
        S_COUNT: begin
          if (idx_q >= lim_q) begin
            idx_q <= '0;
            if (need_q > {{(17-CntW){1'b0}}, avail_q}) begin
              st_q    <= StNoSpace;
              state_q <= S_OUT;
            end else begin
              present_q[req_q.file_id] <= 1'b1;
              if (need_q == 17'd0) begin
                st_q    <= StOk;
                state_q <= S_OUT;
              end else begin
                state_q <= S_ALLOC;
              end
            end
          end else begin
            if (free_q[bi]) avail_q <= avail_q + 1'b1;
            idx_q <= idx_q + 1'b1;
          end
        end
        S_ALLOC: if (out_free) begin
          if (free_q[bi]) begin
            free_q[bi]   <= 1'b0;
            owner_q[bi]  <= req_q.file_id;
            odata_q      <= '{1'b1, 6'(bi), frag_q, StOk,
                              (taken_q + 17'd1 == need_q)};
            taken_q      <= taken_q + 17'd1;
            if (taken_q + 17'd1 == need_q) state_q <= S_IDLE;
          end
          idx_q <= idx_q + 1'b1;
        end
        // The owner entry is read into a register and compared in the following cycle.
        S_REL: begin
          own_rd_q <= owner_q[bi];
          if (idx_q != '0 && !free_q[bi_prev] && own_rd_q == req_q.file_id)
            free_q[bi_prev] <= 1'b1;
          if (idx_q == CntW'(MaxBlocks)) begin
            st_q    <= StOk;
            state_q <= S_OUT;
          end
          idx_q <= idx_q + 1'b1;
        end
        S_OUT: if (out_free) begin
          odata_q  <= '{1'b0, 6'd0, 8'd0, st_q, 1'b1};
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/file_block_allocator.sv @@
// Top level of the file block allocator.
// Channels: req (cmd, file_id, size_bytes) in, res (has_block, block_number,
// fragment, status, last) out, both valid/ready; a beat moves when both are high.
// A two-entry request queue lets new requests be taken while the back end works.
// Per request the back end takes it from the queue; for an allocation it then
// divides the size by the block size (ceiling, by repeated subtraction), counts
// the free blocks among the managed block count (at most 64), then scans the
// blocks, one per cycle while the result register is free, while allocating (one
// result beat per granted block). A release scans all 64 owner entries.
// Status-only results pass through an extra output state.
// Reset frees every block, clears all file ids and loads block_size 127 and
// blocks_in_use 60. A stalled receiver holds the result register and the back
// end waits before it writes the next result; the request queue keeps accepting until full.
// Configuration writes are taken at any cycle with cfg_we_i high.
`default_nettype none
module file_block_allocator import fba_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  fba_req_if.sink    req,
  fba_res_if.source  res,
  input  wire        cfg_we_i,
  input  wire [0:0]  cfg_idx_i,
  input  wire [7:0]  cfg_data_i
);
  logic q_valid, q_pop;
  req_t q_data;

  fba_front u_front (
    .clk_i, .rst_ni, .in(req),
    .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop)
  );

  fba_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .out(res)
  );
endmodule
`default_nettype wire
